// ===== design/keyed_slot_allocator_top_assert.svh =====
// assertion macros used by the allocator top module
`ifndef KEYED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define KEYED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define KSA_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ksa assertion failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define KSA_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ksa assertion failed");

`endif

// ===== design/ksa_pkg.sv =====
package ksa_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;
    localparam int CFG_W    = 9;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    // commands from the sequencer to the key map
    typedef struct packed {
        logic start;
        logic write;
        logic clear;
    } map_cmd_t;

    // scan result from the key map
    typedef struct packed {
        logic done;
        logic hit;
        logic has_empty;
    } map_stat_t;

endpackage

// ===== design/ksa_ram.sv =====
module ksa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ksa_map.sv =====
module ksa_map
    import ksa_pkg::*;
#(
    parameter int MAP_ENTRIES = 64,
    parameter int KEY_BITS    = 32,
    parameter int IW          = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  map_cmd_t            cmd,
    input  logic [KEY_BITS-1:0] key,
    input  logic [IW-1:0]       wr_index,
    output map_stat_t           stat,
    output logic [IW-1:0]       hit_index
);

    localparam int EW = $clog2(MAP_ENTRIES);
    localparam int DW = KEY_BITS + IW;

    logic [MAP_ENTRIES-1:0] valid_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [EW-1:0]          rd_cnt_reg;
    logic [EW-1:0]          cmp_entry_reg;
    logic [EW-1:0]          hit_entry_reg;
    logic [EW-1:0]          empty_entry_reg;
    logic [IW-1:0]          hit_index_reg;
    logic                   valid_rd_reg;
    logic                   busy_reg;
    logic                   cmp_valid_reg;
    logic                   cmp_last_reg;
    logic                   done_reg;
    logic                   hit_reg;
    logic                   empty_reg;

    logic [DW-1:0]          ram_rdata;
    logic [EW-1:0]          ram_waddr;
    logic                   scan_last;
    logic                   entry_hit;
    logic                   entry_free;

    // one entry per cycle: address out, then compare when data returns
    ksa_ram #(
        .WIDTH (DW),
        .DEPTH (MAP_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (ram_waddr),
        .wdata ({key_reg, wr_index}),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    assign ram_waddr  = empty_entry_reg;
    assign scan_last  = (rd_cnt_reg == EW'(MAP_ENTRIES - 1));
    assign entry_hit  = valid_rd_reg && (ram_rdata[IW +: KEY_BITS] == key_reg);
    assign entry_free = !valid_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            busy_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= busy_reg;
            cmp_last_reg  <= busy_reg && scan_last;
            done_reg      <= cmp_valid_reg && cmp_last_reg;
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                hit_reg   <= 1'b0;
                empty_reg <= 1'b0;
            end
            else
            begin
                if (busy_reg && scan_last)
                begin
                    busy_reg <= 1'b0;
                end
                if (cmp_valid_reg && entry_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_valid_reg && entry_free)
                begin
                    empty_reg <= 1'b1;
                end
            end
            if (cmd.write)
            begin
                valid_reg[empty_entry_reg] <= 1'b1;
            end
            if (cmd.clear)
            begin
                valid_reg[hit_entry_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_entry_reg <= rd_cnt_reg;
        // valid bit read alongside the entry memory, lands with its data
        valid_rd_reg  <= valid_reg[rd_cnt_reg];
        if (cmd.start)
        begin
            key_reg    <= key;
            rd_cnt_reg <= '0;
        end
        else if (busy_reg && !scan_last)
        begin
            rd_cnt_reg <= rd_cnt_reg + EW'(1);
        end
        // keys are unique, so the first hit is the only one
        if (cmp_valid_reg && entry_hit && !hit_reg)
        begin
            hit_entry_reg <= cmp_entry_reg;
            hit_index_reg <= ram_rdata[IW-1:0];
        end
        // lowest free entry wins
        if (cmp_valid_reg && entry_free && !empty_reg)
        begin
            empty_entry_reg <= cmp_entry_reg;
        end
    end

    assign stat.done      = done_reg;
    assign stat.hit       = hit_reg;
    assign stat.has_empty = empty_reg;
    assign hit_index      = hit_index_reg;

endmodule

// ===== design/keyed_slot_allocator_top.sv =====
// Keyed slot allocator: binds keys to slot indices. An add reuses the most recently freed index
// once more than min_free freed indices are waiting, otherwise it takes the next fresh index;
// a look-up reports a key's index; a remove unbinds the key and stacks its index for reuse.
// Each operation gives exactly one result. Every operation scans the whole key table, reading
// one entry per cycle from the entry memory; an add that pops a freed index from the free-stack
// memory goes through a pop state first. No new item is taken until the previous result has
// moved into the output register, which holds it until the downstream side takes it. No
// clearing pass is needed after reset. min_free may be written whenever the block is idle.
`include "keyed_slot_allocator_top_assert.svh"

module keyed_slot_allocator_top
    import ksa_pkg::*;
#(
    parameter int MAP_ENTRIES = 64,
    parameter int INDEX_COUNT = 256,
    parameter int KEY_BITS    = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[31:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[2:0], slot_index[10:3], zero[15:11]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data        // min_free
);

    localparam int IW  = $clog2(INDEX_COUNT);
    localparam int FCW = $clog2(INDEX_COUNT + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EXEC = 5'b00100,
        S_POP  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [FCW-1:0]      free_count_reg, free_count_next;
    logic [FCW-1:0]      next_fresh_reg, next_fresh_next;
    logic [CFG_W-1:0]    min_free_reg;
    status_t             status_reg, status_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    logic                in_xfer;
    logic                out_load;
    logic                out_error;
    map_cmd_t            map_cmd;
    map_stat_t           map_stat;
    logic [IW-1:0]       map_hit_index;
    logic [IW-1:0]       map_wr_index;
    logic                free_we;
    logic [IW-1:0]       free_rdata;
    logic [FCW-1:0]      fc_dec;
    logic                reuse_ok;
    logic                fresh_out;
    logic                stack_room;
    logic [63:0]         key_wide;
    logic [31:0]         slot_wide;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign key_wide      = 64'(s_axis_tdata);
    assign fc_dec        = free_count_reg - FCW'(1);
    assign reuse_ok      = (free_count_reg != '0) && (32'(free_count_reg) > 32'(min_free_reg));
    assign fresh_out     = (32'(next_fresh_reg) >= 32'(INDEX_COUNT));
    assign stack_room    = (32'(free_count_reg) < 32'(INDEX_COUNT));
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign slot_wide     = 32'(slot_reg);
    assign out_error     = out_valid_reg && ((out_status_reg == ST_NOT_FOUND) ||
                                             (out_status_reg == ST_FULL) ||
                                             (out_status_reg == ST_EXHAUSTED));

    ksa_map #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .IW          (IW)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (map_cmd),
        .key       (key_wide[KEY_BITS-1:0]),
        .wr_index  (map_wr_index),
        .stat      (map_stat),
        .hit_index (map_hit_index)
    );

    // free stack: push at free_count, pop reads free_count - 1
    ksa_ram #(
        .WIDTH (IW),
        .DEPTH (INDEX_COUNT)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_count_reg[IW-1:0]),
        .wdata (map_hit_index),
        .raddr (fc_dec[IW-1:0]),
        .rdata (free_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        map_cmd         = '0;
        map_wr_index    = next_fresh_reg[IW-1:0];
        free_we         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    map_cmd.start = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (map_stat.done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_DONE;
                status_next = ST_OK;
                slot_next   = '0;
                if (kind_reg == KIND_ADD)
                begin
                    priority if (map_stat.hit)
                    begin
                        status_next = ST_PRESENT;
                        slot_next   = map_hit_index;
                    end
                    else if (!map_stat.has_empty)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (reuse_ok)
                    begin
                        // pop read was issued this cycle, data lands in S_POP
                        free_count_next = fc_dec;
                        state_next      = S_POP;
                    end
                    else if (fresh_out)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        slot_next       = next_fresh_reg[IW-1:0];
                        next_fresh_next = next_fresh_reg + FCW'(1);
                        map_cmd.write   = 1'b1;
                    end
                end
                else if (kind_reg == KIND_REMOVE)
                begin
                    if (map_stat.hit)
                    begin
                        slot_next     = map_hit_index;
                        map_cmd.clear = 1'b1;
                        if (stack_room)
                        begin
                            free_we         = 1'b1;
                            free_count_next = free_count_reg + FCW'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    // look-up, unused kind included
                    if (map_stat.hit)
                    begin
                        slot_next = map_hit_index;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_POP:
            begin
                slot_next     = free_rdata;
                map_wr_index  = free_rdata;
                map_cmd.write = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            next_fresh_reg <= '0;
            min_free_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            if (cfg_valid && cfg_ready)
            begin
                min_free_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
        if (in_xfer)
        begin
            kind_reg <= s_axis_tuser;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_slot_reg   <= slot_wide[SLOT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_slot_reg, out_status_reg};

    `KSA_ASSERT_NXT(a_accept_starts_scan, in_xfer, state_reg == S_SCAN)
    `KSA_ASSERT_IMP(a_pop_had_entry, state_reg == S_POP, $past(free_count_reg) != '0)
    `KSA_ASSERT_IMP(a_freed_not_above_issued, 1'b1, free_count_reg <= next_fresh_reg)
    `KSA_ASSERT_IMP(a_error_slot_zero, out_error, out_slot_reg == '0)
    `KSA_ASSERT_NXT(a_done_fills_output, out_load, out_valid_reg && state_reg == S_IDLE)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ksa_pkg::*;

    localparam int MAP_N     = 64;
    localparam int IDX_N     = 256;
    localparam int POOL_N    = 96;
    localparam int LONG_HOLD = 400;
    localparam int LIMIT     = 600000;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;   // unused code, behaves as a look-up

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } slot_reply_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic              known;   // expectation typed in below
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // key[31:0]
    logic [1:0]  s_axis_tuser = '0;    // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // status[2:0], slot_index[10:3], zero[15:11]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;        // min_free

    // shadow of the key table and index allocator
    logic [KEY_W-1:0]  bound_key   [MAP_N];
    logic              bound_valid [MAP_N];
    logic [SLOT_W-1:0] bound_slot  [MAP_N];
    logic [SLOT_W-1:0] free_slots  [IDX_N];
    int                free_depth;
    int                fresh_next;
    int                reuse_floor;

    slot_reply_t       awaited_replies [$];
    logic [KEY_W-1:0]  key_pool [POOL_N];
    int                errors;
    int                cycles;
    int                gap_odds;
    int                stall_odds;
    bit                hold_off_req;
    bit                hold_off_done;
    int                hold_left;

    dir_row_t dir_rows [21] = '{
        '{KIND_LOOKUP, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 8'd0},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 8'd0},
        '{KIND_ADD,    32'h0000_0000, 1'b1, ST_OK,        8'd0},
        '{KIND_ADD,    32'hFFFF_FFFF, 1'b1, ST_OK,        8'd1},
        '{KIND_ADD,    32'h0000_0000, 1'b1, ST_PRESENT,   8'd0},
        '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1, ST_OK,        8'd1},
        '{KIND_SPARE,  32'h0000_0000, 1'b1, ST_OK,        8'd0},
        '{KIND_REMOVE, 32'h0000_0000, 1'b1, ST_OK,        8'd0},
        '{KIND_ADD,    32'h1234_5678, 1'b1, ST_OK,        8'd0},
        '{KIND_REMOVE, 32'h1234_5678, 1'b1, ST_OK,        8'd0},
        '{KIND_LOOKUP, 32'h1234_5678, 1'b1, ST_NOT_FOUND, 8'd0},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, ST_OK,        8'd1},
        '{KIND_ADD,    32'hA5A5_A5A5, 1'b1, ST_OK,        8'd1},
        '{KIND_ADD,    32'h5A5A_5A5A, 1'b1, ST_OK,        8'd0},
        '{KIND_SPARE,  32'h8000_0000, 1'b1, ST_NOT_FOUND, 8'd0},
        '{KIND_ADD,    32'h0000_0001, 1'b0, ST_OK,        8'd0},
        '{KIND_REMOVE, 32'hA5A5_A5A5, 1'b0, ST_OK,        8'd0},
        '{KIND_ADD,    32'h7FFF_FFFF, 1'b0, ST_OK,        8'd0},
        '{KIND_LOOKUP, 32'h5A5A_5A5A, 1'b0, ST_OK,        8'd0},
        '{KIND_REMOVE, 32'h0000_0001, 1'b0, ST_OK,        8'd0},
        '{KIND_LOOKUP, 32'h0000_0001, 1'b0, ST_OK,        8'd0}
    };

    keyed_slot_allocator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // applies one table operation to the shadow state and returns its reply
    function automatic slot_reply_t predict_slot_op(input logic [KIND_W-1:0] kind,
                                                    input logic [KEY_W-1:0] key);
        slot_reply_t r;
        int hit;
        int empty;
        r.status = ST_OK;
        r.slot = '0;
        hit = -1;
        empty = -1;
        for (int i = 0; i < MAP_N; i++)
        begin
            if (hit < 0 && bound_valid[i] && bound_key[i] == key)
                hit = i;
            if (empty < 0 && !bound_valid[i])
                empty = i;
        end
        if (kind == KIND_ADD)
        begin
            if (hit >= 0)
            begin
                r.status = ST_PRESENT;
                r.slot = bound_slot[hit];
            end
            else if (empty < 0)
                r.status = ST_FULL;
            else if (free_depth > 0 && free_depth > reuse_floor)
            begin
                free_depth--;
                r.slot = free_slots[free_depth];
            end
            else if (fresh_next >= IDX_N)
                r.status = ST_EXHAUSTED;
            else
            begin
                r.slot = SLOT_W'(fresh_next);
                fresh_next++;
            end
            if (hit < 0 && r.status == ST_OK)
            begin
                bound_key[empty] = key;
                bound_slot[empty] = r.slot;
                bound_valid[empty] = 1'b1;
            end
        end
        else if (kind == KIND_REMOVE)
        begin
            if (hit < 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                r.slot = bound_slot[hit];
                bound_valid[hit] = 1'b0;
                if (free_depth < IDX_N)
                begin
                    free_slots[free_depth] = r.slot;
                    free_depth++;
                end
            end
        end
        else if (hit < 0)
            r.status = ST_NOT_FOUND;
        else
            r.slot = bound_slot[hit];
        return r;
    endfunction

    // a key currently bound in the table, or a pool key if the table is empty
    function automatic logic [KEY_W-1:0] pick_bound_key();
        int start;
        start = $urandom_range(0, MAP_N - 1);
        for (int i = 0; i < MAP_N; i++)
            if (bound_valid[(start + i) % MAP_N])
                return bound_key[(start + i) % MAP_N];
        return key_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic known, input slot_reply_t typed);
        slot_reply_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= key;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_slot_op(kind, key);
        awaited_replies.push_back(known ? typed : predicted);
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic set_reuse_threshold(input int value);
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= 9'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reuse_floor = value;
    endtask

    // mixes adds, removes and look-ups; most keys come from a small pool or the table itself
    task automatic run_traffic(input int count, input int add_pct, input int rm_pct,
                               input int hold_at);
        int r;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_off_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < add_pct)
            begin
                kind = KIND_ADD;
                key = ($urandom_range(0, 4) == 0) ? $urandom()
                                                  : key_pool[$urandom_range(0, POOL_N - 1)];
            end
            else
            begin
                if (r < add_pct + rm_pct)
                    kind = KIND_REMOVE;
                else
                    kind = ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_LOOKUP;
                key = ($urandom_range(0, 5) == 0) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                                  : pick_bound_key();
            end
            send_op(kind, key, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // result side: check each transfer, then decide the next ready
    always @(posedge clk)
    begin
        slot_reply_t want;
        status_t got_status;
        logic [SLOT_W-1:0] got_slot;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_status = status_t'(m_axis_tdata[2:0]);
            got_slot = m_axis_tdata[10:3];
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected result status %0d slot %0d",
                         $time, got_status, got_slot);
                errors++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got_status != want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got_status);
                    errors++;
                end
                if (got_slot != want.slot)
                begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, got_slot);
                    errors++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off_req && !hold_off_done)
        begin
            hold_off_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
        begin
            hold_left <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_left = 0;
        hold_off_req = 1'b0;
        hold_off_done = 1'b0;
        free_depth = 0;
        fresh_next = 0;
        reuse_floor = 0;
        for (int i = 0; i < MAP_N; i++)
        begin
            bound_valid[i] = 1'b0;
            bound_key[i] = '0;
            bound_slot[i] = '0;
        end
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = $urandom();
        gap_odds = 4;
        stall_odds = 4;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].known,
                    '{dir_rows[i].status, dir_rows[i].slot});
        s_axis_tvalid <= 1'b0;

        // fill the table until adds come back full; receiver holds off for a while
        set_reuse_threshold(0);
        run_traffic(200, 70, 15, 20);

        // threshold out of reach: every add takes a fresh index until they run out
        gap_odds = 10;
        stall_odds = 12;
        set_reuse_threshold(256);
        run_traffic(600, 55, 40, -1);

        gap_odds = 3;
        stall_odds = 3;
        set_reuse_threshold($urandom_range(1, 8));
        run_traffic(300, 50, 35, -1);

        set_reuse_threshold(255);
        run_traffic(150, 45, 35, -1);

        // closing stretch at full rate
        gap_odds = 0;
        stall_odds = 0;
        set_reuse_threshold(0);
        run_traffic(200, 45, 35, -1);

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
